// ===== src/prsctr_pkg.sv =====
// shared types, constants and round functions for the present-80 counter-mode keystream unit
// no dependencies; imported by every module of the block
package prsctr_pkg;

  localparam int ROUND_COUNT = 31;
  localparam int RC_W        = 5;
  localparam int KEY_W       = 80;
  localparam int BLK_W       = 64;
  localparam int WORD_W      = 32;
  localparam int KEY_UP_W    = 16;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 1;
  // input register, one stage per round, output register
  localparam int LATENCY     = ROUND_COUNT + 2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 1'b1;

  localparam logic [3:0] SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  typedef struct packed {
    logic [BLK_W-1:0]  state;
    logic [KEY_W-1:0]  key;
    logic [WORD_W-1:0] pay;
  } stage_t;

  function automatic logic [BLK_W-1:0] sub_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int n = 0; n < BLK_W / 4; n++) begin
      r[4*n +: 4] = SBOX[s[4*n +: 4]];
    end
    return r;
  endfunction

  // bit i moves to 16*i mod 63, the top bit stays put
  function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int i = 0; i < BLK_W; i++) begin
      if (i == BLK_W - 1) begin
        r[BLK_W-1] = s[i];
      end else begin
        r[(i * 16) % (BLK_W - 1)] = s[i];
      end
    end
    return r;
  endfunction

  // rotate left 61, s-box on the top nibble, round counter into bits 19..15
  function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                  input logic [RC_W-1:0]  rc);
    logic [KEY_W-1:0] r;
    r          = {k[18:0], k[KEY_W-1:19]};
    r[79:76]   = SBOX[r[79:76]];
    r[19:15]   = r[19:15] ^ rc;
    return r;
  endfunction

endpackage

// ===== src/prsctr_round.sv =====
// one registered present-80 round: key add, s-box layer, bit permutation and key schedule step
// depends on prsctr_pkg
module prsctr_round (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  prsctr_pkg::stage_t            in_stage,
  input  logic [prsctr_pkg::RC_W-1:0]   rc,
  output logic                          out_vld,
  output prsctr_pkg::stage_t            out_stage
);
  import prsctr_pkg::*;

  stage_t stage_next;

  always_comb begin
    stage_next.state = perm_layer(sub_layer(in_stage.state ^ in_stage.key[KEY_W-1 -: BLK_W]));
    stage_next.key   = key_update(in_stage.key, rc);
    stage_next.pay   = in_stage.pay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_stage <= stage_next;
  end

endmodule

// ===== src/present80_ctr_keystream.sv =====
// top level of the present-80 counter-mode keystream unit: key registers, input stage,
// round pipeline and output stage; depends on prsctr_pkg and prsctr_round
//
//   channel   handshake              payload
//   -------   ---------------------  ------------------------------------------
//   command   start / busy           sequence_number, timestamp_ms, payload_in
//   result    done (one-cycle)       keystream_block, payload_out
//   config    cfg_we                 cfg_index, cfg_wdata
//
// a new transaction can be taken every cycle; busy stays low
// each result passes through one input register, one register per
// round (31 rounds) and the output register holding the final key add
// the key travels through the round stages next to the block, each stage doing one key
// schedule step, so the pipeline depth sets the latency
// synchronous reset clears the key registers and all stage valid bits; data is not reset
// the receiver cannot stall, so the pipeline never holds and nothing waits on the output
module present80_ctr_keystream (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [prsctr_pkg::WORD_W-1:0]       sequence_number,
  input  logic [prsctr_pkg::WORD_W-1:0]       timestamp_ms,
  input  logic [prsctr_pkg::WORD_W-1:0]       payload_in,
  output logic                                done,
  output logic [prsctr_pkg::BLK_W-1:0]        keystream_block,
  output logic [prsctr_pkg::WORD_W-1:0]       payload_out,
  input  logic                                cfg_we,
  input  logic [prsctr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prsctr_pkg::CFG_W-1:0]        cfg_wdata
);
  import prsctr_pkg::*;

  // configured cipher key, bits 79..64 and 63..0
  logic [KEY_UP_W-1:0] key_upper;
  logic [BLK_W-1:0]    key_lower;

  // stage 0 is the input register, stage i holds the state after round i
  stage_t stage [ROUND_COUNT+1];
  logic   vld   [ROUND_COUNT+1];

  logic [BLK_W-1:0] ks_next;

  // the pipeline never stalls
  assign busy = 1'b0;

  // configuration writes; the user must make them only while no transaction is in flight, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      key_upper <= '0;
      key_lower <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_UPPER: key_upper <= cfg_wdata[KEY_UP_W-1:0];
        REG_KEY_LOWER: key_lower <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // input register: counter block is sequence number over timestamp
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    stage[0].state <= {sequence_number, timestamp_ms};
    stage[0].key   <= {key_upper, key_lower};
    stage[0].pay   <= payload_in;
  end

  // one registered stage per round, round counter runs from 1
  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    prsctr_round u_round (
      .clk       (clk),
      .rst       (rst),
      .in_vld    (vld[g]),
      .in_stage  (stage[g]),
      .rc        (RC_W'(g + 1)),
      .out_vld   (vld[g+1]),
      .out_stage (stage[g+1])
    );
  end

  // final whitening with the last round key
  assign ks_next = stage[ROUND_COUNT].state ^ stage[ROUND_COUNT].key[KEY_W-1 -: BLK_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[ROUND_COUNT];
    end
  end

  // payload takes the upper half of the keystream
  always_ff @(posedge clk) begin
    keystream_block <= ks_next;
    payload_out     <= stage[ROUND_COUNT].pay ^ ks_next[BLK_W-1 -: WORD_W];
  end

endmodule

// ===== src/prsctr_checker.sv =====
// port-level checker for the present-80 counter-mode keystream unit, bound to the top level
// depends on prsctr_pkg and present80_ctr_keystream
module prsctr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic [prsctr_pkg::WORD_W-1:0]       payload_in,
  input logic                                done,
  input logic [prsctr_pkg::BLK_W-1:0]        keystream_block,
  input logic [prsctr_pkg::WORD_W-1:0]       payload_out
);
  import prsctr_pkg::*;

  // every accepted transaction gives a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done)
    else $error("no result after accepted transaction");

  // no result without a transaction accepted the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching transaction");

  // payload out is the payload in of the same transaction masked by the keystream
  a_payload_mask: assert property (@(posedge clk) disable iff (rst)
    done |-> (payload_out ^ keystream_block[BLK_W-1 -: WORD_W]) == $past(payload_in, LATENCY))
    else $error("payload out does not match keystream mask");

  // the pipeline never refuses a command
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

endmodule

bind present80_ctr_keystream prsctr_checker u_prsctr_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .payload_in      (payload_in),
  .done            (done),
  .keystream_block (keystream_block),
  .payload_out     (payload_out)
);

// ===== bench/tb_present80_ctr_keystream.sv =====
// self-checking bench for the present-80 counter-mode keystream unit: a directed table, then
// random key phases; depends on prsctr_pkg and present80_ctr_keystream
`timescale 1ns / 1ps

module tb_present80_ctr_keystream;

  // one keystream transaction as it leaves the block
  typedef struct packed {
    logic [63:0] ks;
    logic [31:0] pay;
  } keystream_res_t;

  // directed row: key words to load, counter block, payload, and an optional
  // published keystream value typed in where it is known by heart
  typedef struct packed {
    logic [63:0] key_up_w;
    logic [63:0] key_lo_w;
    logic [31:0] seq;
    logic [31:0] ts;
    logic [31:0] pay;
    logic        known;
    logic [63:0] known_ks;
  } ctr_vector_t;

  localparam int N_DIRECTED     = 18;
  localparam int N_PHASES       = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int MAX_GAP        = 18;
  localparam int MAX_PRINTS     = 40;

  // all-zero and all-one keys and blocks give the published test vectors; upper key words
  // with junk above bit 15 check that only the low 16 bits are kept
  localparam ctr_vector_t DIRECTED [N_DIRECTED] = '{
    '{64'h0, 64'h0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 64'h5579C1387B228445},
    '{64'h0, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 64'hA112FFC72F68417B},
    '{64'h0, 64'h0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_A5A5, 1'b0, 64'h0},
    '{64'h0, 64'h0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0, 64'h0},
    '{64'h0, 64'h0, 32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b0, 64'h0},
    '{64'h0, 64'h0, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 1'b1, 64'hE72C46C0F5945049},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'h0000_0000, 1'b1, 64'h3333DCD3213210D2},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0,
      32'hDEAD_BEEF, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 1'b0, 64'h0},
    '{64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 1'b0, 64'h0},
    '{64'h0000_0000_0000_FFFF, 64'h0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      1'b0, 64'h0},
    '{64'h0000_0000_0000_FFFF, 64'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
      1'b0, 64'h0},
    '{64'hDEAD_BEEF_0000_8000, 64'h0000_0000_0000_0001, 32'h0000_0001, 32'h0000_0000,
      32'h0F0F_0F0F, 1'b0, 64'h0},
    '{64'hDEAD_BEEF_0000_8000, 64'h0000_0000_0000_0001, 32'h0000_0001, 32'h0000_0001,
      32'hF0F0_F0F0, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0123, 64'h4567_89AB_CDEF_0123, 32'hC0FF_EE00, 32'h0000_FFFF,
      32'h1357_9BDF, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0123, 64'h4567_89AB_CDEF_0123, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h2468_ACE0, 1'b0, 64'h0},
    '{64'h0000_0000_0000_0123, 64'h4567_89AB_CDEF_0123, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 1'b0, 64'h0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  // command side
  logic        start           = 1'b0;
  logic        busy;
  logic [31:0] sequence_number = '0;
  logic [31:0] timestamp_ms    = '0;
  logic [31:0] payload_in      = '0;

  // result side
  logic        done;
  logic [63:0] keystream_block;
  logic [31:0] payload_out;

  // key register write port
  logic                                   cfg_we    = 1'b0;
  logic [prsctr_pkg::CFG_IDX_W-1:0]       cfg_index = prsctr_pkg::REG_KEY_UPPER;
  logic [prsctr_pkg::CFG_W-1:0]           cfg_wdata = '0;

  // shadow of the 80-bit key as the block should hold it
  logic [79:0]    key_shadow = '0;
  // keystream results still owed by the block, oldest first
  keystream_res_t pending_keystream [$];
  keystream_res_t oldest;

  int mismatches     = 0;
  int blocks_sent    = 0;
  int results_seen   = 0;
  int key_loads      = 0;

  present80_ctr_keystream dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .sequence_number (sequence_number),
    .timestamp_ms    (timestamp_ms),
    .payload_in      (payload_in),
    .done            (done),
    .keystream_block (keystream_block),
    .payload_out     (payload_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #1 clk = ~clk;

  // the present 4-bit s-box
  function automatic logic [3:0] sbox_lookup(input logic [3:0] x);
    case (x)
      4'h0: return 4'hC;
      4'h1: return 4'h5;
      4'h2: return 4'h6;
      4'h3: return 4'hB;
      4'h4: return 4'h9;
      4'h5: return 4'h0;
      4'h6: return 4'hA;
      4'h7: return 4'hD;
      4'h8: return 4'h3;
      4'h9: return 4'hE;
      4'hA: return 4'hF;
      4'hB: return 4'h8;
      4'hC: return 4'h4;
      4'hD: return 4'h7;
      4'hE: return 4'h1;
      default: return 4'h2;
    endcase
  endfunction

  // full present-80 encryption of one counter block: round key is the top 64 key bits,
  // key schedule is rotate left 61, s-box on the top nibble, round counter into 19..15
  function automatic logic [63:0] present80_encrypt(input logic [79:0] key,
                                                    input logic [63:0] blk);
    logic [79:0] k;
    logic [63:0] s;
    logic [63:0] t;
    k = key;
    s = blk;
    for (int r = 1; r <= prsctr_pkg::ROUND_COUNT; r++) begin
      s = s ^ k[79:16];
      for (int n = 0; n < 16; n++) begin
        t[4*n +: 4] = sbox_lookup(s[4*n +: 4]);
      end
      // bit i lands on 16*i mod 63, the top bit stays where it is
      for (int i = 0; i < 63; i++) begin
        s[(i * 16) % 63] = t[i];
      end
      s[63] = t[63];
      k = {k[18:0], k[79:19]};
      k[79:76] = sbox_lookup(k[79:76]);
      k[19:15] = k[19:15] ^ r[4:0];
    end
    return s ^ k[79:16];
  endfunction

  // one line per mismatch, capped so a broken block cannot flood the log
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    end
  endtask

  // lower start and wait until every owed result has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_keystream.size() != 0) @(posedge clk);
  endtask

  // write both key registers on back-to-back edges, then drop the write enable
  task automatic load_key(input logic [63:0] up_w, input logic [63:0] lo_w);
    cfg_we    <= 1'b1;
    cfg_index <= prsctr_pkg::REG_KEY_UPPER;
    cfg_wdata <= up_w;
    @(posedge clk);
    cfg_index <= prsctr_pkg::REG_KEY_LOWER;
    cfg_wdata <= lo_w;
    @(posedge clk);
    cfg_we     <= 1'b0;
    // only bits 15..0 of the upper word belong to the key
    key_shadow = {up_w[15:0], lo_w};
    key_loads++;
  endtask

  // present one counter-block transaction after an idle gap; start stays high on return
  // so that a following transaction with no gap goes in on the very next edge
  task automatic issue_counter_block(input logic [31:0] s, input logic [31:0] t,
                                     input logic [31:0] p, input int gap,
                                     input logic typed, input logic [63:0] typed_ks);
    keystream_res_t want;
    if (typed) begin
      want.ks = typed_ks;
    end else begin
      want.ks = present80_encrypt(key_shadow, {s, t});
    end
    want.pay = p ^ want.ks[63:32];
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    sequence_number <= s;
    timestamp_ms    <= t;
    payload_in      <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_keystream.push_back(want);
    blocks_sent++;
  endtask

  // result checker: every strobe must match the oldest owed transaction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_keystream.size() == 0) begin
        report_mismatch("unexpected result, keystream", keystream_block, 64'h0);
      end else begin
        oldest = pending_keystream.pop_front();
        results_seen++;
        if (keystream_block !== oldest.ks) begin
          report_mismatch("keystream_block", keystream_block, oldest.ks);
        end
        if (payload_out !== oldest.pay) begin
          report_mismatch("payload_out", {32'h0, payload_out}, {32'h0, oldest.pay});
        end
      end
    end
  end

  // main stimulus
  initial begin
    logic [63:0] cur_up_w;
    logic [63:0] cur_lo_w;
    logic [63:0] up_w;
    logic [63:0] lo_w;
    logic [31:0] seq;
    logic [31:0] ts;
    logic [31:0] pay;
    int          gap;
    int          idle_style;
    int          kind;

    cur_up_w = '0;
    cur_lo_w = '0;
    seq      = '0;
    ts       = '0;

    // synchronous reset, held from time zero and then released
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: the first rows run on the key left by reset; a new key is only
    // loaded once the pipe has emptied
    for (int row = 0; row < N_DIRECTED; row++) begin
      if (DIRECTED[row].key_up_w != cur_up_w || DIRECTED[row].key_lo_w != cur_lo_w) begin
        wait_drained();
        load_key(DIRECTED[row].key_up_w, DIRECTED[row].key_lo_w);
        cur_up_w = DIRECTED[row].key_up_w;
        cur_lo_w = DIRECTED[row].key_lo_w;
      end
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, MAX_GAP) : 0;
      issue_counter_block(DIRECTED[row].seq, DIRECTED[row].ts, DIRECTED[row].pay, gap,
                          DIRECTED[row].known, DIRECTED[row].known_ks);
    end

    // random phases, one key per phase; the key is only changed with the pipe empty
    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin
          up_w = {$urandom, $urandom};
          lo_w = {$urandom, $urandom};
        end
        1: begin
          up_w = '0;
          lo_w = '0;
        end
        2: begin
          up_w = '1;
          lo_w = '1;
        end
        default: begin
          up_w = {$urandom, $urandom};
          lo_w = {32'h0, $urandom};
        end
      endcase
      load_key(up_w, lo_w);
      // back-to-back, uneven gaps, or mostly back-to-back with the odd pause
      idle_style = phase % 3;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        case (idle_style)
          0:       gap = 0;
          1:       gap = $urandom_range(0, MAX_GAP);
          default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
        endcase
        // mostly a real counter stream: sequence steps now and then, timestamp climbs and
        // wraps; the rest is noise and the all-zero / all-one corners
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
          seq = seq + (($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0);
          ts  = ts + $urandom_range(1, 1000);
        end else if (kind <= 7) begin
          seq = $urandom;
          ts  = $urandom;
        end else if (kind == 8) begin
          seq = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
          ts  = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
        end else begin
          seq = $urandom;
          ts  = 32'hFFFF_FFFF - $urandom_range(0, 500);
        end
        pay = ($urandom_range(0, 15) == 0) ? {32{1'($urandom_range(0, 1))}} : $urandom;
        // every so often hold the sender off until the pipe has emptied completely
        if ($urandom_range(0, 39) == 0) begin
          wait_drained();
        end
        issue_counter_block(seq, ts, pay, gap, 1'b0, 64'h0);
      end
    end

    // let the pipe empty, then watch a little longer for stray strobes
    wait_drained();
    repeat (prsctr_pkg::LATENCY + 8) @(posedge clk);

    $display("ran %0d counter blocks under %0d key loads, %0d keystream results checked",
             blocks_sent, key_loads, results_seen);
    $display("%0d field mismatches or stray results seen", mismatches);
    if (mismatches == 0 && pending_keystream.size() == 0) begin
      $display("present80_ctr_keystream verification clean");
    end else begin
      $display("present80_ctr_keystream verification failed");
    end
    $finish;
  end

  // watchdog: set far beyond the slowest legal run
  initial begin
    #2000000;
    $display("present80_ctr_keystream verification failed");
    $finish;
  end

endmodule
